### rtl/ptpp_pkg.sv
// ----------------------------------------------------------------------------
// ptpp_pkg: shared constants and gather functions
// Tile geometry, port widths and the planar-to-packed bit gather.
// ----------------------------------------------------------------------------
package ptpp_pkg;

    localparam int unsigned ROWS        = 16;
    localparam int unsigned ROW_W       = $clog2(ROWS);
    localparam int unsigned POS_W       = 7;           // byte index in a 128-byte tile
    localparam int unsigned TILE_CNT_W  = 20;
    localparam int unsigned STORE_W     = 32;
    localparam int unsigned HOLD_W      = 24;
    localparam int unsigned PENS        = 16;
    localparam int unsigned PIX_W       = 64;
    localparam int unsigned OUT_DATA_W  = 88;          // pixels, row, tile index

    localparam logic [1:0]       LAST_BYTE_OF_GROUP = 2'd3;
    localparam logic [ROW_W-1:0] LAST_ROW           = ROW_W'(ROWS - 1);
    localparam logic [PENS-1:0]  PEN_ZERO_CLEAR     = 16'hFFFE;

    // Pixel x takes pen {b3[x], b1[x], b2[x], b0[x]}; pixel 0 in the top nibble.
    function automatic logic [31:0] gather_half(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [7:0] b3);
        logic [31:0] dw;
        dw = '0;
        for (int x = 0; x < 8; x++) begin
            dw[(7 - x) * 4 +: 4] = {b3[x], b1[x], b2[x], b0[x]};
        end
        return dw;
    endfunction

    // Set of pens used by eight packed pixels.
    function automatic logic [PENS-1:0] pens_used(input logic [31:0] dw);
        logic [PENS-1:0] m;
        m = '0;
        for (int x = 0; x < 8; x++) begin
            m[dw[x * 4 +: 4]] = 1'b1;
        end
        return m;
    endfunction

endpackage

### rtl/planar_tile_to_packed_pixels_core.sv
// ----------------------------------------------------------------------------
// planar_tile_to_packed_pixels_core: 4-bitplane tile to packed 4bpp rows
// Converts 128-byte planar 16x16 tiles into sixteen 64-bit packed rows.
// ----------------------------------------------------------------------------
// One tile byte enters per cycle. The first 64 bytes of a tile (right halves
// of the rows) are assembled four at a time and written as one 32-bit word
// into a 16-entry RAM. In the second 64 bytes, the first byte of each group
// of four issues the RAM read for that row; the fourth byte completes the
// row, which is gathered and loaded into the output register in the same
// cycle. So each tile yields 16 words after 128 accepted bytes, and a row
// is presented in the cycle after its fourth byte is taken. The input side
// stalls only when a second-half fourth byte arrives while the output
// register still holds a row the downstream has not taken; every other
// byte is taken regardless. A RAM write (first half) and a RAM read (second
// half) never touch the same tile half at once, so no forwarding is needed.
// tile_class on the last row is 1 when the whole tile used pen 0 only.
// ----------------------------------------------------------------------------
module planar_tile_to_packed_pixels_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] tile_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,    // [63:0] row_pixels, [67:64] row_number,
                                           // [87:68] tile_number
    output logic        o_m_axis_tlast,    // last_row
    output logic        o_m_axis_tuser     // tile_class
);

    // Tile walk state.
    logic [ptpp_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [ptpp_pkg::HOLD_W-1:0]     r_hold, n_hold;
    logic [ptpp_pkg::PENS-1:0]       r_pen_mask, n_pen_mask;
    logic [ptpp_pkg::TILE_CNT_W-1:0] r_tile_cnt, n_tile_cnt;

    // Output register.
    logic                            r_out_valid, n_out_valid;
    logic [ptpp_pkg::PIX_W-1:0]      r_out_pix;
    logic [ptpp_pkg::ROW_W-1:0]      r_out_row;
    logic [ptpp_pkg::TILE_CNT_W-1:0] r_out_tile;
    logic                            r_out_last;
    logic                            r_out_class;

    logic                            in_acc;
    logic                            second_half;
    logic [1:0]                      grp;
    logic [ptpp_pkg::ROW_W-1:0]      row;
    logic                            row_byte;     // fourth byte of a second-half group
    logic                            emit;
    logic                            is_last;
    logic                            ram_we;
    logic                            ram_re;
    logic [ptpp_pkg::STORE_W-1:0]    ram_rdata;
    logic [31:0]                     left_dw;
    logic [31:0]                     right_dw;
    logic [ptpp_pkg::PENS-1:0]       row_pens;
    logic [ptpp_pkg::PENS-1:0]       tile_pens;

    assign second_half = r_pos[ptpp_pkg::POS_W-1];
    assign grp         = r_pos[1:0];
    assign row         = r_pos[ptpp_pkg::ROW_W+1:2];
    assign row_byte    = second_half && (grp == ptpp_pkg::LAST_BYTE_OF_GROUP);
    assign is_last     = (row == ptpp_pkg::LAST_ROW);

    // Take any byte, except a row-completing one while the output is stuck.
    assign o_s_axis_tready = !(row_byte && r_out_valid && !i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign emit            = in_acc && row_byte;

    // Write a full right-half word on the fourth first-half byte; read it back
    // on the first byte of the matching second-half group.
    assign ram_we = in_acc && !second_half && (grp == ptpp_pkg::LAST_BYTE_OF_GROUP);
    assign ram_re = in_acc && second_half && (grp == 2'd0);

    ptpp_ram #(
        .WIDTH (ptpp_pkg::STORE_W),
        .DEPTH (ptpp_pkg::ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (row),
        .i_wdata ({i_s_axis_tdata, r_hold}),
        .i_re    (ram_re),
        .i_raddr (row),
        .o_rdata (ram_rdata)
    );

    // Gather both halves of the row.
    assign left_dw   = ptpp_pkg::gather_half(r_hold[7:0], r_hold[15:8], r_hold[23:16],
                                             i_s_axis_tdata);
    assign right_dw  = ptpp_pkg::gather_half(ram_rdata[7:0], ram_rdata[15:8],
                                             ram_rdata[23:16], ram_rdata[31:24]);
    assign row_pens  = ptpp_pkg::pens_used(left_dw) | ptpp_pkg::pens_used(right_dw);
    assign tile_pens = r_pen_mask | row_pens;

    always_comb begin
        n_pos      = r_pos;
        n_hold     = r_hold;
        n_pen_mask = r_pen_mask;
        n_tile_cnt = r_tile_cnt;
        if (in_acc) begin
            n_pos = r_pos + 1'b1;
            case (grp)
                2'd0:    n_hold[7:0]   = i_s_axis_tdata;
                2'd1:    n_hold[15:8]  = i_s_axis_tdata;
                2'd2:    n_hold[23:16] = i_s_axis_tdata;
                default: n_hold        = r_hold;
            endcase
        end
        if (emit) begin
            if (is_last) begin
                // Close the tile: drop the pen history, advance the index.
                n_pos      = '0;
                n_pen_mask = '0;
                n_tile_cnt = r_tile_cnt + 1'b1;
            end else begin
                n_pen_mask = tile_pens;
            end
        end
    end

    // Hold the row until taken; a new row may load in the cycle it leaves.
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_hold      <= '0;
            r_pen_mask  <= '0;
            r_tile_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_hold      <= n_hold;
            r_pen_mask  <= n_pen_mask;
            r_tile_cnt  <= n_tile_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pix   <= {left_dw, right_dw};
            r_out_row   <= row;
            r_out_tile  <= r_tile_cnt;
            r_out_last  <= is_last;
            r_out_class <= is_last && ((tile_pens & ptpp_pkg::PEN_ZERO_CLEAR) == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_tile, r_out_row, r_out_pix};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_class;

    // The input stalls only behind a full, blocked output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a blocked output row");

    // Closing a tile rewinds the walk and clears the pen history.
    a_tile_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && is_last) |=> (r_pos == '0 && r_pen_mask == '0))
        else $error("tile walk did not rewind after the last row");

    // The invisible flag only rides on a last row.
    a_class_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("tile class flagged on a row other than the last");

    // The last-row flag is set exactly when the row number is the last row.
    a_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[67:64] == ptpp_pkg::LAST_ROW)))
        else $error("last row flag disagrees with row number");

endmodule

### rtl/ptpp_ram.sv
// ----------------------------------------------------------------------------
// ptpp_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered, held between reads.
// ----------------------------------------------------------------------------
module ptpp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
